### rtl/sorted_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Condition holds at every edge out of reset
`define SPQ_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define SPQ_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define SPQ_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Sizes, command and status codes, and transfer types of the sorted queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int QUEUE_DEPTH    = 16;
	localparam int ELEMENT_WIDTH  = 32;
	localparam int PRIORITY_WIDTH = 32;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ELEMENT_WIDTH-1:0]  elem_t;
	typedef logic [PRIORITY_WIDTH-1:0] prio_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [IDX_W:0]            pos_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [QUEUE_DEPTH-1:0]    dep_vec_t;
	typedef logic [2:0]                opcode_t;
	typedef logic [1:0]                status_t;

	// Command codes
	localparam opcode_t OP_INSERT   = 3'd0;
	localparam opcode_t OP_REM_HEAD = 3'd1;
	localparam opcode_t OP_REM_ELEM = 3'd2;
	localparam opcode_t OP_CHANGE   = 3'd3;
	localparam opcode_t OP_CONTAINS = 3'd4;
	localparam opcode_t OP_CLEAR    = 3'd5;
	localparam opcode_t OP_FIRST    = 3'd6;
	localparam opcode_t OP_NEXT     = 3'd7;

	// Result status codes
	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_NOT_FOUND = 2'd1;
	localparam status_t STAT_FULL      = 2'd2;

	typedef struct packed {
		opcode_t     opcode;
		logic [31:0] element;
		logic [31:0] priority_req;
		logic [31:0] repl_priority;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic        found;
		logic [31:0] read_element;
		logic        read_valid;
		logic [4:0]  entry_count;
	} rsp_t;

	// One queue entry held by a cell
	typedef struct packed {
		elem_t elem;
		prio_t prio;
	} entry_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic cmp;
		logic ins;
		logic shl;
	} cell_ctl_t;

	// Per-cell compare results
	typedef struct packed {
		logic ge;
		logic me;
		logic mb;
	} cell_flag_t;

endpackage

`default_nettype wire

### rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast key and takes data from either neighbor on insert or removal.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire                 clk,
	input  spq_pkg::cell_ctl_t  ctl,
	input  wire                 occ,
	input  spq_pkg::entry_t     key,
	input  spq_pkg::entry_t     ins,
	input  wire                 left_ge,
	input  spq_pkg::entry_t     left,
	input  spq_pkg::entry_t     right,
	output spq_pkg::entry_t     ent,
	output spq_pkg::cell_flag_t flag
);

	spq_pkg::entry_t     ent_q;
	spq_pkg::cell_flag_t flag_q;

	// Latch compare results against the broadcast key
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			flag_q.ge <= occ && (ent_q.prio >= key.prio);
			flag_q.me <= occ && (ent_q.elem == key.elem);
			flag_q.mb <= occ && (ent_q.elem == key.elem) && (ent_q.prio == key.prio);
		end
	end

	// Hold, take the new entry, shift in from the left, or shift in from the right
	always_ff @(posedge clk) begin
		priority if (ctl.ins) begin
			if (!flag_q.ge) begin
				if (left_ge) begin
					ent_q <= ins;
				end else begin
					ent_q <= left;
				end
			end
		end else if (ctl.shl) begin
			ent_q <= right;
		end
	end

	assign ent  = ent_q;
	assign flag = flag_q;

endmodule

`default_nettype wire

### rtl/spq_ctrl.sv
// ---------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: takes commands, drives the cell chain, keeps the
// occupancy and read iterator, and registers the result transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_defines.svh"

module spq_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_stall,
	input  spq_pkg::cmd_t       cmd,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output spq_pkg::rsp_t       rsp,
	input  spq_pkg::entry_t     ents  [spq_pkg::QUEUE_DEPTH],
	input  spq_pkg::cell_flag_t flags [spq_pkg::QUEUE_DEPTH],
	output spq_pkg::cell_ctl_t  ctls  [spq_pkg::QUEUE_DEPTH],
	output spq_pkg::dep_vec_t   occ,
	output spq_pkg::entry_t     key,
	output spq_pkg::entry_t     ins
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_WAIT = 2'd3;

	logic [1:0]        state_q, state_d;
	spq_pkg::cmd_t     cmd_q;
	logic              reins_q, reins_d;
	spq_pkg::cnt_t     count_q, count_d;
	logic              iter_active_q, iter_active_d;
	spq_pkg::idx_t     iter_pos_q, iter_pos_d;
	spq_pkg::rsp_t     rsp_q, res_q, res;
	logic              rsp_valid_q;

	logic              accept, out_free, finish, load_rsp, to_cmp, ins_en, cmp_en;
	spq_pkg::dep_vec_t rm_vec, shl_vec, me_vec, mb_vec;
	spq_pkg::pos_t     next_pos;
	spq_pkg::dep_vec_t low_mask;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmp_en    = accept || (state_q == S_CMP);
	assign next_pos  = spq_pkg::pos_t'(iter_pos_q) + spq_pkg::pos_t'(1);

	// Gather cell flags and occupancy
	always_comb begin
		for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
			me_vec[i] = flags[i].me;
			mb_vec[i] = flags[i].mb;
			occ[i]    = spq_pkg::cnt_t'(i) < count_q;
		end
	end

	// Broadcast compare key: the incoming command, or the new priority on reinsert
	always_comb begin
		if (state_q == S_IDLE) begin
			key.elem = spq_pkg::elem_t'(cmd.element);
			key.prio = spq_pkg::prio_t'(cmd.priority_req);
		end else begin
			key.elem = spq_pkg::elem_t'(cmd_q.element);
			key.prio = spq_pkg::prio_t'(cmd_q.repl_priority);
		end
	end

	assign ins.elem = spq_pkg::elem_t'(cmd_q.element);
	assign ins.prio = reins_q ? spq_pkg::prio_t'(cmd_q.repl_priority)
	                          : spq_pkg::prio_t'(cmd_q.priority_req);

	// Execute the command against the latched cell flags
	always_comb begin
		ins_en        = 1'b0;
		rm_vec        = '0;
		to_cmp        = 1'b0;
		reins_d       = reins_q;
		count_d       = count_q;
		iter_active_d = iter_active_q;
		iter_pos_d    = iter_pos_q;
		res           = '0;
		res.status    = spq_pkg::STAT_OK;
		if (state_q == S_EXEC) begin
			priority if (reins_q) begin
				ins_en  = 1'b1;
				reins_d = 1'b0;
				count_d = count_q + spq_pkg::cnt_t'(1);
			end else begin
				unique case (cmd_q.opcode)
					spq_pkg::OP_INSERT: begin
						iter_active_d = 1'b0;
						if (count_q == spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH)) begin
							res.status = spq_pkg::STAT_FULL;
						end else begin
							ins_en  = 1'b1;
							count_d = count_q + spq_pkg::cnt_t'(1);
						end
					end
					spq_pkg::OP_REM_HEAD: begin
						iter_active_d = 1'b0;
						if (count_q != '0) begin
							rm_vec  = spq_pkg::dep_vec_t'(1);
							count_d = count_q - spq_pkg::cnt_t'(1);
						end
					end
					spq_pkg::OP_REM_ELEM: begin
						iter_active_d = 1'b0;
						if (|me_vec) begin
							rm_vec  = me_vec;
							count_d = count_q - spq_pkg::cnt_t'(1);
						end else begin
							res.status = spq_pkg::STAT_NOT_FOUND;
						end
					end
					spq_pkg::OP_CHANGE: begin
						iter_active_d = 1'b0;
						if (|mb_vec) begin
							rm_vec  = mb_vec;
							count_d = count_q - spq_pkg::cnt_t'(1);
							to_cmp  = 1'b1;
							reins_d = 1'b1;
						end else begin
							res.status = spq_pkg::STAT_NOT_FOUND;
						end
					end
					spq_pkg::OP_CONTAINS: begin
						res.found = |me_vec;
					end
					spq_pkg::OP_CLEAR: begin
						iter_active_d = 1'b0;
						iter_pos_d    = '0;
						count_d       = '0;
					end
					spq_pkg::OP_FIRST: begin
						if (count_q != '0) begin
							iter_active_d    = 1'b1;
							iter_pos_d       = '0;
							res.read_element = 32'(ents[0].elem);
							res.read_valid   = 1'b1;
						end
					end
					spq_pkg::OP_NEXT: begin
						if (iter_active_q && (next_pos < spq_pkg::pos_t'(count_q)) &&
						    (next_pos < spq_pkg::pos_t'(spq_pkg::QUEUE_DEPTH))) begin
							iter_pos_d       = next_pos[spq_pkg::IDX_W-1:0];
							res.read_element = 32'(ents[next_pos[spq_pkg::IDX_W-1:0]].elem);
							res.read_valid   = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
		res.entry_count = 5'(count_d);
	end

	// Turn the first match into a left shift from that slot to the tail
	always_comb begin
		for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
			low_mask   = {spq_pkg::QUEUE_DEPTH{1'b1}} >> (spq_pkg::QUEUE_DEPTH - 1 - i);
			shl_vec[i] = |(rm_vec & low_mask);
		end
	end

	always_comb begin
		for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
			ctls[i].cmp = cmp_en;
			ctls[i].ins = ins_en;
			ctls[i].shl = shl_vec[i];
		end
	end

	assign finish   = (state_q == S_EXEC) && !to_cmp;
	assign load_rsp = out_free && (finish || (state_q == S_WAIT));

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (to_cmp) begin
					state_d = S_CMP;
				end else if (out_free) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_WAIT;
				end
			end
			S_CMP: begin
				state_d = S_EXEC;
			end
			S_WAIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			reins_q       <= 1'b0;
			count_q       <= '0;
			iter_active_q <= 1'b0;
			iter_pos_q    <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			reins_q       <= reins_d;
			count_q       <= count_d;
			iter_active_q <= iter_active_d;
			iter_pos_q    <= iter_pos_d;
			rsp_valid_q   <= load_rsp || (rsp_valid_q && rsp_stall);
		end
	end

	// Hold command, parked result and output transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (finish && !out_free) begin
			res_q <= res;
		end
		if (load_rsp) begin
			rsp_q <= (state_q == S_WAIT) ? res_q : res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SPQ_CHECK(a_count_bound, count_q <= spq_pkg::cnt_t'(spq_pkg::QUEUE_DEPTH), "occupancy above depth")
	`SPQ_IMPLY(a_ins_no_shift, ins_en, shl_vec == '0, "insert and removal in one cycle")
	`SPQ_IMPLY(a_wait_pending, state_q == S_WAIT, rsp_valid_q, "parked result without output")
	`SPQ_IMPLY(a_reins_change, reins_q, cmd_q.opcode == spq_pkg::OP_CHANGE, "reinsert outside change priority")
	`SPQ_NEXT(a_accept_exec, accept, state_q == S_EXEC, "accepted command not executed")

endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue of 16 entries kept in descending priority order,
// first in first out among equal priorities, built as a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one command (opcode, element, priority, new priority); it
//   transfers on a clock edge with cmd_valid high and cmd_stall low.
//   rsp returns exactly one result per command, with the same handshake on
//   rsp_valid / rsp_stall, in command order.
// Timing:
//   A command is taken in one cycle and executed in the next, and cmd_stall
//   stays high until it has finished. Change priority runs a removal
//   pass, a second compare with the new priority, then the insertion pass.
//   All cells compare in parallel and shift by one slot per pass; the
//   sequencer works on one command at a time.
//   rsp_valid is registered from the final execute pass of each command.
// Stalls and reset:
//   A result waiting on rsp does not block the next command; if a second
//   result is ready while rsp is still stalled, it is parked and cmd_stall
//   stays high until rsp drains.
//   Reset empties the queue, drops the read iterator and any pending result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cmd_valid,
	output logic          cmd_stall,
	input  spq_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  wire           rsp_stall,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::entry_t     ent_w  [spq_pkg::QUEUE_DEPTH];
	spq_pkg::cell_flag_t flag_w [spq_pkg::QUEUE_DEPTH];
	spq_pkg::cell_ctl_t  ctl_w  [spq_pkg::QUEUE_DEPTH];
	spq_pkg::dep_vec_t   occ_w;
	spq_pkg::entry_t     key_w;
	spq_pkg::entry_t     ins_w;

	// Sequencer
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.ents      (ent_w),
		.flags     (flag_w),
		.ctls      (ctl_w),
		.occ       (occ_w),
		.key       (key_w),
		.ins       (ins_w)
	);

	// Cell chain: head at slot 0, each cell wired to both neighbors
	genvar i;
	for (i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_ent;
		spq_pkg::entry_t right_ent;
		logic            left_ge;

		if (i == 0) begin : g_head
			assign left_ge  = 1'b1;
			assign left_ent = ins_w;
		end else begin : g_body
			assign left_ge  = flag_w[i-1].ge;
			assign left_ent = ent_w[i-1];
		end

		if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_tail
			assign right_ent = ent_w[i];
		end else begin : g_mid
			assign right_ent = ent_w[i+1];
		end

		spq_cell u_cell (
			.clk     (clk),
			.ctl     (ctl_w[i]),
			.occ     (occ_w[i]),
			.key     (key_w),
			.ins     (ins_w),
			.left_ge (left_ge),
			.left    (left_ent),
			.right   (right_ent),
			.ent     (ent_w[i]),
			.flag    (flag_w[i])
		);
	end

endmodule

`default_nettype wire

### tb/sv/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. Commands are queued up
// front, driven with random gaps, and run through a local sorted-list model
// when they transfer; each response is compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 90;

	typedef struct {
		spq_pkg::cmd_t cmd;
		int            gap;
		bit            aim;
		bit            pause;
	} cmd_plan_t;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_stall;
	spq_pkg::cmd_t cmd       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	spq_pkg::rsp_t rsp;

	// Stimulus and scoreboard state
	cmd_plan_t     cmd_backlog[$];
	spq_pkg::rsp_t predicted_rsp[$];
	bit            rush;
	bit            pause_next;
	bit            cmd_taken;
	bit            rsp_taken;
	bit            rsp_quiet;
	int            gap_left;
	int            stall_left;
	int            rsp_count;
	int            idle_cycles;
	int            mismatch_count;

	// Queue contents as predicted, head at slot 0
	logic [31:0] held_elem[spq_pkg::QUEUE_DEPTH];
	logic [31:0] held_prio[spq_pkg::QUEUE_DEPTH];
	int          held_count = 0;
	int          walk_pos   = 0;
	bit          walk_on    = 1'b0;

	sorted_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Close the gap left by the entry at idx
	function automatic void drop_slot(int idx);
		for (int i = idx; i + 1 < held_count; i++) begin
			held_elem[i] = held_elem[i + 1];
			held_prio[i] = held_prio[i + 1];
		end
		held_count--;
	endfunction

	// Insert behind every entry of greater or equal priority
	function automatic bit place_sorted(logic [31:0] e, logic [31:0] p);
		int slot;
		slot = 0;
		if (held_count >= spq_pkg::QUEUE_DEPTH)
			return 1'b0;
		while (slot < held_count && held_prio[slot] >= p)
			slot++;
		for (int i = held_count; i > slot; i--) begin
			held_elem[i] = held_elem[i - 1];
			held_prio[i] = held_prio[i - 1];
		end
		held_elem[slot] = e;
		held_prio[slot] = p;
		held_count++;
		return 1'b1;
	endfunction

	// First slot holding the element (and the priority, if asked), or -1
	function automatic int find_slot(logic [31:0] e, logic [31:0] p, bit match_prio);
		int hit;
		hit = -1;
		for (int i = 0; i < held_count; i++)
			if (hit < 0 && held_elem[i] == e && (!match_prio || held_prio[i] == p))
				hit = i;
		return hit;
	endfunction

	// Apply one command to the predicted queue and return its response
	function automatic spq_pkg::rsp_t apply_command(spq_pkg::cmd_t c);
		spq_pkg::rsp_t r;
		int            hit;
		r = '0;
		r.status = spq_pkg::STAT_OK;
		case (c.opcode)
			spq_pkg::OP_INSERT: begin
				walk_on = 1'b0;
				if (!place_sorted(c.element, c.priority_req))
					r.status = spq_pkg::STAT_FULL;
			end
			spq_pkg::OP_REM_HEAD: begin
				walk_on = 1'b0;
				if (held_count > 0)
					drop_slot(0);
			end
			spq_pkg::OP_REM_ELEM: begin
				walk_on = 1'b0;
				hit = find_slot(c.element, '0, 1'b0);
				if (hit >= 0)
					drop_slot(hit);
				else
					r.status = spq_pkg::STAT_NOT_FOUND;
			end
			spq_pkg::OP_CHANGE: begin
				walk_on = 1'b0;
				hit = find_slot(c.element, c.priority_req, 1'b1);
				if (hit >= 0) begin
					drop_slot(hit);
					void'(place_sorted(c.element, c.repl_priority));
				end else begin
					r.status = spq_pkg::STAT_NOT_FOUND;
				end
			end
			spq_pkg::OP_CONTAINS: begin
				r.found = (find_slot(c.element, '0, 1'b0) >= 0);
			end
			spq_pkg::OP_CLEAR: begin
				held_count = 0;
				walk_on = 1'b0;
				walk_pos = 0;
			end
			spq_pkg::OP_FIRST: begin
				if (held_count > 0) begin
					walk_on = 1'b1;
					walk_pos = 0;
					r.read_element = held_elem[0];
					r.read_valid = 1'b1;
				end
			end
			default: begin
				if (walk_on && walk_pos + 1 < held_count) begin
					walk_pos++;
					r.read_element = held_elem[walk_pos];
					r.read_valid = 1'b1;
				end
			end
		endcase
		r.entry_count = 5'(held_count);
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Mostly small values so that matches and ties happen, sometimes extremes
	function automatic logic [31:0] pick_value(int pool);
		case ($urandom_range(0, 15))
			0:       return 32'hFFFF_FFFF;
			1:       return 32'h0;
			2:       return $urandom();
			default: return $urandom_range(0, pool);
		endcase
	endfunction

	task automatic post_cmd(spq_pkg::opcode_t op, logic [31:0] e, logic [31:0] p,
			logic [31:0] np, bit aim);
		cmd_plan_t plan;
		plan.cmd.opcode        = op;
		plan.cmd.element       = e;
		plan.cmd.priority_req  = p;
		plan.cmd.repl_priority = np;
		plan.gap   = rush ? 0 : $urandom_range(0, 11);
		plan.aim   = aim;
		plan.pause = pause_next;
		pause_next = 1'b0;
		cmd_backlog.push_back(plan);
	endtask

	// Command with random contents in the fields it ignores
	task automatic post_bare(spq_pkg::opcode_t op);
		post_cmd(op, $urandom(), $urandom(), $urandom(), 1'b0);
	endtask

	// Drive commands: hold until transfer, then wait out the next gap
	always @(negedge clk) begin
		cmd_plan_t     plan;
		logic          offer;
		spq_pkg::cmd_t payload;
		int            pick;
		offer = cmd_valid;
		payload = cmd;
		if (arst_n) begin
			if (cmd_valid && cmd_taken) begin
				offer = 1'b0;
				cmd_taken = 1'b0;
				if (cmd_backlog.size() != 0)
					gap_left = cmd_backlog[0].gap;
			end
			if (!offer && cmd_backlog.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!cmd_backlog[0].pause || predicted_rsp.size() == 0) begin
					plan = cmd_backlog.pop_front();
					// Aim at a present entry; nothing else is in flight on this side
					if (plan.aim && held_count > 0) begin
						pick = $urandom_range(0, held_count - 1);
						plan.cmd.element = held_elem[pick];
						if (plan.cmd.opcode == spq_pkg::OP_CHANGE)
							plan.cmd.priority_req = held_prio[pick];
					end
					offer = 1'b1;
					payload = plan.cmd;
				end
			end
		end
		cmd_valid <= offer;
		cmd <= payload;
	end

	// Drive the response stall: a random wait per result, a long hold twice
	always @(negedge clk) begin
		if (rsp_taken) begin
			rsp_taken = 1'b0;
			if ($urandom_range(0, 39) == 0)
				rsp_quiet = !rsp_quiet;
			if (rsp_count == 120 || rsp_count == 520)
				stall_left = LONG_HOLD;
			else if (rsp_quiet)
				stall_left = 0;
			else
				stall_left = $urandom_range(0, 11);
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Check responses against the oldest prediction, then predict new commands
	always @(posedge clk) begin
		spq_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_taken = 1'b1;
				rsp_count++;
				if (predicted_rsp.size() == 0) begin
					$error("response 0x%0h with no command outstanding", rsp);
					mismatch_count++;
				end else begin
					want = predicted_rsp.pop_front();
					compare_field("status", want.status, rsp.status);
					compare_field("found", want.found, rsp.found);
					compare_field("read_element", want.read_element, rsp.read_element);
					compare_field("read_valid", want.read_valid, rsp.read_valid);
					compare_field("entry_count", want.entry_count, rsp.entry_count);
				end
			end
			if (cmd_valid && !cmd_stall) begin
				cmd_taken = 1'b1;
				predicted_rsp.push_back(apply_command(cmd));
			end
		end
	end

	// Abort when no transfer happens on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		spq_pkg::opcode_t op;

		// Directed: empty queue corners
		rush = 1'b0;
		pause_next = 1'b0;
		post_bare(spq_pkg::OP_FIRST);
		post_bare(spq_pkg::OP_NEXT);
		post_bare(spq_pkg::OP_REM_HEAD);
		post_cmd(spq_pkg::OP_REM_ELEM, 32'd7, $urandom(), $urandom(), 1'b0);
		post_cmd(spq_pkg::OP_CONTAINS, 32'd7, $urandom(), $urandom(), 1'b0);
		post_cmd(spq_pkg::OP_CHANGE, 32'd7, 32'd1, 32'd2, 1'b0);
		// Extremes, an equal-priority pair and a duplicate element
		post_cmd(spq_pkg::OP_INSERT, 32'h0, 32'h0, $urandom(), 1'b0);
		post_cmd(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom(), 1'b0);
		post_cmd(spq_pkg::OP_INSERT, 32'd5, 32'd7, $urandom(), 1'b0);
		post_cmd(spq_pkg::OP_INSERT, 32'd6, 32'd7, $urandom(), 1'b0);
		post_cmd(spq_pkg::OP_INSERT, 32'd5, 32'd3, $urandom(), 1'b0);
		// Walk the whole queue and one step past its end
		post_bare(spq_pkg::OP_FIRST);
		repeat (5) post_bare(spq_pkg::OP_NEXT);
		post_cmd(spq_pkg::OP_CONTAINS, 32'd5, $urandom(), $urandom(), 1'b0);
		post_cmd(spq_pkg::OP_CONTAINS, 32'h1234, $urandom(), $urandom(), 1'b0);
		// Move to the top priority, then miss on a wrong old priority
		post_cmd(spq_pkg::OP_CHANGE, 32'd5, 32'd3, 32'hFFFF_FFFF, 1'b0);
		post_cmd(spq_pkg::OP_CHANGE, 32'd6, 32'd3, 32'd9, 1'b0);
		post_bare(spq_pkg::OP_NEXT);
		post_cmd(spq_pkg::OP_REM_ELEM, 32'd5, $urandom(), $urandom(), 1'b0);
		post_bare(spq_pkg::OP_REM_HEAD);
		post_bare(spq_pkg::OP_CLEAR);

		// Random phases; the first one waits for the directed part to drain
		pause_next = 1'b1;
		while (cmd_backlog.size() < 825) begin
			rush = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0)
				pause_next = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat ($urandom_range(10, 30)) begin
						case ($urandom_range(0, 19))
							0, 1, 2, 3, 4, 5, 6: op = spq_pkg::OP_INSERT;
							7, 8:                op = spq_pkg::OP_REM_HEAD;
							9, 10:               op = spq_pkg::OP_REM_ELEM;
							11, 12:              op = spq_pkg::OP_CHANGE;
							13, 14:              op = spq_pkg::OP_CONTAINS;
							15:                  op = spq_pkg::OP_CLEAR;
							16:                  op = spq_pkg::OP_FIRST;
							default:             op = spq_pkg::OP_NEXT;
						endcase
						post_cmd(op, pick_value(9), pick_value(4), pick_value(4),
							$urandom_range(0, 1));
					end
				end
				3: begin
					// Fill close to full or past it, then read everything back
					post_bare(spq_pkg::OP_CLEAR);
					repeat ($urandom_range(14, 19))
						post_cmd(spq_pkg::OP_INSERT, pick_value(9), pick_value(4),
							$urandom(), 1'b0);
					post_bare(spq_pkg::OP_FIRST);
					repeat (17) post_bare(spq_pkg::OP_NEXT);
				end
				4: begin
					post_bare(spq_pkg::OP_FIRST);
					repeat ($urandom_range(0, 17)) post_bare(spq_pkg::OP_NEXT);
				end
				5: begin
					repeat ($urandom_range(4, 12)) begin
						post_cmd(spq_pkg::OP_CHANGE, pick_value(9), pick_value(4),
							pick_value(4), $urandom_range(0, 3) != 0);
						if ($urandom_range(0, 2) == 0) begin
							post_bare(spq_pkg::OP_FIRST);
							post_bare(spq_pkg::OP_NEXT);
						end
					end
				end
				6: begin
					repeat ($urandom_range(1, 17)) post_bare(spq_pkg::OP_REM_HEAD);
				end
				7: begin
					// Noise: any opcode, full-range fields
					repeat ($urandom_range(5, 15))
						post_cmd(spq_pkg::opcode_t'($urandom_range(0, 7)), $urandom(),
							$urandom(), $urandom(), 1'b0);
				end
				8: begin
					repeat ($urandom_range(4, 12))
						post_cmd(spq_pkg::OP_INSERT, pick_value(9), pick_value(4),
							$urandom(), 1'b0);
				end
				default: begin
					repeat ($urandom_range(4, 10))
						post_cmd($urandom_range(0, 1) ? spq_pkg::OP_REM_ELEM
							: spq_pkg::OP_CONTAINS,
							pick_value(9), $urandom(), $urandom(), $urandom_range(0, 1));
				end
			endcase
		end

		// Reset, released on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every command to transfer and every response to return
		while (cmd_backlog.size() != 0 || cmd_valid || predicted_rsp.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (predicted_rsp.size() != 0) begin
			$error("%0d responses never arrived", predicted_rsp.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
